[sv/tabular_q_learning_agent_assert.svh]
// Assertion macros shared by the agent RTL.
`ifndef TABULAR_Q_LEARNING_AGENT_ASSERT_SVH
`define TABULAR_Q_LEARNING_AGENT_ASSERT_SVH

// Same-cycle implication.
`define TQLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tabular_q_learning_agent: assertion failed");

// Next-cycle implication.
`define TQLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tabular_q_learning_agent: assertion failed");

`endif

[sv/tqla_pkg.sv]
package tqla_pkg;

    localparam int DATA_W    = 16;
    localparam int FIELD_W   = 2;
    localparam int CFG_IDX_W = 3;

    // Opcodes
    localparam logic [FIELD_W-1:0] OP_SELECT = 2'd0;
    localparam logic [FIELD_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [FIELD_W-1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_DECAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRAINING_ON   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [DATA_W-1:0] LEARN_RATE_RST    = 16'd19661;
    localparam logic [DATA_W-1:0] DISCOUNT_RST      = 16'd58982;
    localparam logic [DATA_W-1:0] EXPLORE_DECAY_RST = 16'd65208;
    localparam logic [DATA_W-1:0] EXPLORE_FLOOR_RST = 16'd0;
    localparam logic [DATA_W-1:0] EXPLORE_START_RST = 16'd26214;

    typedef logic signed [DATA_W-1:0] t_q88;

    // Stage enables of the update datapath
    typedef struct packed {
        logic mul1;
        logic sum;
        logic mul2;
    } t_upd_ctrl;

endpackage

[sv/tqla_ram.sv]
module tqla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tqla_upd.sv]
module tqla_upd (
    input  logic                              i_clk,
    input  tqla_pkg::t_upd_ctrl               i_ctrl,
    input  logic [tqla_pkg::DATA_W-1:0]       i_learn_rate,
    input  logic [tqla_pkg::DATA_W-1:0]       i_discount,
    input  tqla_pkg::t_q88                    i_reward,
    input  tqla_pkg::t_q88                    i_row_max,
    input  tqla_pkg::t_q88                    i_entry,
    output tqla_pkg::t_q88                    o_new_value
);
    import tqla_pkg::*;

    localparam int GM_W    = 2 * DATA_W + 1;        // Q8.24 gamma * max
    localparam int TGT_W   = GM_W + 2;              // Q8.24 target, with headroom
    localparam int PROD_W  = TGT_W + DATA_W + 1;    // Q8.40 alpha * target
    localparam int DELTA_W = PROD_W - 2 * DATA_W;   // Q8.8 step after the shift
    localparam int SUM_W   = DELTA_W + 1;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'd2147483648);
    localparam logic signed [SUM_W-1:0]  Q_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0]  Q_MIN = -SUM_W'(32768);

    logic signed [GM_W-1:0]    r_gm;
    logic signed [TGT_W-1:0]   r_target;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [TGT_W-1:0]   tgt_reward;
    logic signed [TGT_W-1:0]   tgt_gm;
    logic signed [TGT_W-1:0]   tgt_entry;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;

    always_comb begin
        tgt_reward = {{(TGT_W-2*DATA_W){i_reward[DATA_W-1]}}, i_reward, {DATA_W{1'b0}}};
        tgt_entry  = {{(TGT_W-2*DATA_W){i_entry[DATA_W-1]}}, i_entry, {DATA_W{1'b0}}};
        tgt_gm     = {{(TGT_W-GM_W){r_gm[GM_W-1]}}, r_gm};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul1) begin
            r_gm <= $signed({1'b0, i_discount}) * i_row_max;
        end
        if (i_ctrl.sum) begin
            r_target <= tgt_reward + tgt_gm - tgt_entry;
        end
        if (i_ctrl.mul2) begin
            r_prod <= $signed({1'b0, i_learn_rate}) * r_target;
        end
    end

    // Round half up, floor to Q8.8, add to the entry and saturate.
    always_comb begin
        rounded = r_prod + HALF;
        delta   = rounded[PROD_W-1:2*DATA_W];
        sum     = {{(SUM_W-DATA_W){i_entry[DATA_W-1]}}, i_entry} + {delta[DELTA_W-1], delta};
        if (sum > Q_MAX) begin
            o_new_value = 16'sh7FFF;
        end else if (sum < Q_MIN) begin
            o_new_value = 16'sh8000;
        end else begin
            o_new_value = sum[DATA_W-1:0];
        end
    end

endmodule

[sv/tabular_q_learning_agent.sv]
// Select: row scan (S_SCAN), S_DRAIN, S_FIN; update with training on: row scan, S_ENTRY,
// S_GMUL, S_TGT, S_AMUL, S_WB; every other item: S_FIN. The result strobe is registered
// from S_WB or S_FIN. The row scan reads one table entry per cycle through the single
// memory read port. A word is taken only while idle, as early as the edge that ends its
// predecessor's strobe. Synchronous reset clears the table (by valid bits), loads all
// register defaults and sets epsilon to the starting value; the receiver cannot stall.
`include "tabular_q_learning_agent_assert.svh"

module tabular_q_learning_agent #(
    parameter int STATE_COUNT  = 3,
    parameter int ACTION_COUNT = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tqla_pkg::FIELD_W-1:0]        i_opcode,
    input  logic [tqla_pkg::FIELD_W-1:0]        i_cur_state,
    input  logic [tqla_pkg::FIELD_W-1:0]        i_taken_action,
    input  logic [tqla_pkg::FIELD_W-1:0]        i_following_state,
    input  logic signed [tqla_pkg::DATA_W-1:0]  i_reward_value,
    input  logic [tqla_pkg::DATA_W-1:0]         i_random_draw,
    input  logic [tqla_pkg::FIELD_W-1:0]        i_random_action,
    input  logic                                i_cfg_we,
    input  logic [tqla_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tqla_pkg::DATA_W-1:0]         i_cfg_data,
    output logic                                o_done,
    output logic [tqla_pkg::FIELD_W-1:0]        o_chosen_action,
    output logic                                o_explored,
    output logic signed [tqla_pkg::DATA_W-1:0]  o_new_value,
    output logic [tqla_pkg::DATA_W-1:0]         o_epsilon_now
);
    import tqla_pkg::*;

    localparam int DEPTH  = STATE_COUNT * ACTION_COUNT;
    localparam int ST_W   = $clog2(STATE_COUNT);
    localparam int AC_W   = $clog2(ACTION_COUNT);
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_ENTRY = 4'd3;
    localparam logic [3:0] S_GMUL  = 4'd4;
    localparam logic [3:0] S_TGT   = 4'd5;
    localparam logic [3:0] S_AMUL  = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]        r_state;
    logic [3:0]        n_state;

    // Configuration and epsilon
    logic [DATA_W-1:0] r_learn_rate;
    logic [DATA_W-1:0] r_discount;
    logic [DATA_W-1:0] r_decay;
    logic [DATA_W-1:0] r_floor;
    logic [DATA_W-1:0] r_start_eps;
    logic              r_train;
    logic [DATA_W-1:0] r_eps;

    // Latched command word
    logic [FIELD_W-1:0] r_op;
    logic [ST_W-1:0]    r_row;
    logic [ST_W-1:0]    r_cs;
    logic [AC_W-1:0]    r_ta;
    logic [AC_W-1:0]    r_ra;
    t_q88               r_reward;
    logic [DATA_W-1:0]  r_draw;

    // Row scan
    logic [AC_W-1:0]    r_idx;
    logic               r_pend_scan;
    logic [AC_W-1:0]    r_pend_act;
    t_q88               r_best;
    logic [AC_W-1:0]    r_best_act;
    t_q88               r_entry;

    // Table memory
    logic [DEPTH-1:0]   r_valid;
    logic               r_rd_ok;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  scan_addr;
    logic [ADDR_W-1:0]  entry_addr;
    logic [DATA_W-1:0]  ram_q;
    t_q88               rd_val;
    logic               ram_we;

    // Output registers
    logic               r_done;
    logic [FIELD_W-1:0] r_chosen;
    logic               r_explored;
    t_q88               r_new_value;
    logic [DATA_W-1:0]  r_eps_out;

    logic [ST_W-1:0]    cs_c;
    logic [ST_W-1:0]    fs_c;
    logic [AC_W-1:0]    ta_c;
    logic [AC_W-1:0]    ra_c;
    logic               accept;
    logic               explore;
    logic [2*DATA_W-1:0] eps_prod;
    logic [DATA_W-1:0]  eps_decayed;
    t_upd_ctrl          upd_ctrl;
    t_q88               upd_nv;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Out-of-range indexes take the last row or column.
    always_comb begin
        cs_c = (int'(i_cur_state) >= STATE_COUNT) ? ST_W'(STATE_COUNT - 1)
                                                  : ST_W'(i_cur_state);
        fs_c = (int'(i_following_state) >= STATE_COUNT) ? ST_W'(STATE_COUNT - 1)
                                                        : ST_W'(i_following_state);
        ta_c = (int'(i_taken_action) >= ACTION_COUNT) ? AC_W'(ACTION_COUNT - 1)
                                                      : AC_W'(i_taken_action);
        ra_c = (int'(i_random_action) >= ACTION_COUNT) ? AC_W'(ACTION_COUNT - 1)
                                                       : AC_W'(i_random_action);
    end

    assign scan_addr  = ADDR_W'(int'(r_row) * ACTION_COUNT + int'(r_idx));
    assign entry_addr = ADDR_W'(int'(r_cs) * ACTION_COUNT + int'(r_ta));
    assign rd_addr    = (r_state == S_ENTRY) ? entry_addr : scan_addr;
    assign ram_we     = (r_state == S_WB);
    assign rd_val     = r_rd_ok ? $signed(ram_q) : '0;

    assign explore     = r_train && (r_draw < r_eps);
    assign eps_prod    = r_eps * r_decay;
    assign eps_decayed = (r_eps > r_floor) ? eps_prod[2*DATA_W-1:DATA_W] : r_eps;

    assign upd_ctrl.mul1 = (r_state == S_GMUL);
    assign upd_ctrl.sum  = (r_state == S_TGT);
    assign upd_ctrl.mul2 = (r_state == S_AMUL);

    tqla_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (entry_addr),
        .i_wdata (upd_nv),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    tqla_upd u_upd (
        .i_clk        (i_clk),
        .i_ctrl       (upd_ctrl),
        .i_learn_rate (r_learn_rate),
        .i_discount   (r_discount),
        .i_reward     (r_reward),
        .i_row_max    (r_best),
        .i_entry      (r_entry),
        .o_new_value  (upd_nv)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_SELECT || (i_opcode == OP_UPDATE && r_train)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == AC_W'(ACTION_COUNT - 1)) begin
                    n_state = (r_op == OP_UPDATE) ? S_ENTRY : S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_FIN;
            S_ENTRY: n_state = S_GMUL;
            S_GMUL:  n_state = S_TGT;
            S_TGT:   n_state = S_AMUL;
            S_AMUL:  n_state = S_WB;
            S_WB:    n_state = S_IDLE;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_scan <= 1'b0;
            r_done      <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_pend_scan <= (r_state == S_SCAN);
            r_done      <= (r_state == S_WB) || (r_state == S_FIN);
            if (r_state == S_FIN && r_op == OP_CLEAR) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[entry_addr] <= 1'b1;
            end
        end
    end

    // Configuration, training flag and epsilon
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate <= LEARN_RATE_RST;
            r_discount   <= DISCOUNT_RST;
            r_decay      <= EXPLORE_DECAY_RST;
            r_floor      <= EXPLORE_FLOOR_RST;
            r_start_eps  <= EXPLORE_START_RST;
            r_train      <= 1'b1;
            r_eps        <= EXPLORE_START_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEARN_RATE:    r_learn_rate <= i_cfg_data;
                REG_DISCOUNT:      r_discount   <= i_cfg_data;
                REG_EXPLORE_DECAY: r_decay      <= i_cfg_data;
                REG_EXPLORE_FLOOR: r_floor      <= i_cfg_data;
                REG_EXPLORE_START: r_start_eps  <= i_cfg_data;
                REG_TRAINING_ON: begin
                    r_train <= i_cfg_data[0];
                    if (!i_cfg_data[0]) begin
                        r_eps <= '0;
                    end
                end
                default: ;
            endcase
        end else if (r_state == S_FIN && r_op == OP_CLEAR) begin
            r_train <= 1'b1;
            r_eps   <= r_start_eps;
        end else if (r_state == S_WB) begin
            r_eps <= eps_decayed;
        end
    end

    // Command word, scan and results
    always_ff @(posedge i_clk) begin
        r_rd_ok    <= r_valid[rd_addr];
        r_pend_act <= r_idx;
        if (accept) begin
            r_op     <= i_opcode;
            r_row    <= (i_opcode == OP_SELECT) ? cs_c : fs_c;
            r_cs     <= cs_c;
            r_ta     <= ta_c;
            r_ra     <= ra_c;
            r_reward <= i_reward_value;
            r_draw   <= i_random_draw;
            r_idx    <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + 1'b1;
        end
        // First highest value wins: replace only on a strictly larger value.
        if (r_pend_scan && (r_pend_act == '0 || rd_val > r_best)) begin
            r_best     <= rd_val;
            r_best_act <= r_pend_act;
        end
        if (r_state == S_GMUL) begin
            r_entry <= rd_val;
        end
        if (r_state == S_WB) begin
            r_chosen    <= '0;
            r_explored  <= 1'b0;
            r_new_value <= upd_nv;
            r_eps_out   <= eps_decayed;
        end else if (r_state == S_FIN) begin
            r_new_value <= '0;
            if (r_op == OP_SELECT) begin
                r_explored <= explore;
                r_chosen   <= explore ? FIELD_W'(r_ra) : FIELD_W'(r_best_act);
            end else begin
                r_explored <= 1'b0;
                r_chosen   <= '0;
            end
            r_eps_out <= (r_op == OP_CLEAR) ? r_start_eps : r_eps;
        end
    end

    assign o_done          = r_done;
    assign o_chosen_action = r_chosen;
    assign o_explored      = r_explored;
    assign o_new_value     = r_new_value;
    assign o_epsilon_now   = r_eps_out;

    `TQLA_ASSERT_IMP(a_done_after_work, i_clk, i_rst_n, o_done, $past(busy))
    `TQLA_ASSERT_IMP(a_done_when_idle, i_clk, i_rst_n, o_done, !busy)
    `TQLA_ASSERT_NXT(a_accept_goes_busy, i_clk, i_rst_n, accept, busy)
    `TQLA_ASSERT_IMP(a_eps_zero_untrained, i_clk, i_rst_n, !r_train, r_eps == '0)
    `TQLA_ASSERT_IMP(a_explore_no_update, i_clk, i_rst_n, o_done && o_explored, o_new_value == '0)

endmodule

[test/tb_tabular_q_learning_agent.sv]
module tb_tabular_q_learning_agent;
    import tqla_pkg::*;

    localparam int STATES      = 3;
    localparam int ACTIONS     = 3;
    localparam int SETTLE      = ACTIONS + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 190;

    localparam logic [FIELD_W-1:0]   OP_NOP      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] opcode;
        logic [FIELD_W-1:0] cur_state;
        logic [FIELD_W-1:0] taken_action;
        logic [FIELD_W-1:0] following_state;
        logic [DATA_W-1:0]  reward;
        logic [DATA_W-1:0]  draw;
        logic [FIELD_W-1:0] rand_action;
    } t_agent_cmd;

    typedef struct packed {
        logic [FIELD_W-1:0] chosen_action;
        logic               explored;
        logic [DATA_W-1:0]  new_value;
        logic [DATA_W-1:0]  epsilon_now;
    } t_agent_reply;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FIELD_W-1:0]   i_opcode = '0;
    logic [FIELD_W-1:0]   i_cur_state = '0;
    logic [FIELD_W-1:0]   i_taken_action = '0;
    logic [FIELD_W-1:0]   i_following_state = '0;
    logic signed [DATA_W-1:0] i_reward_value = '0;
    logic [DATA_W-1:0]    i_random_draw = '0;
    logic [FIELD_W-1:0]   i_random_action = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DATA_W-1:0]    i_cfg_data = '0;
    logic                 o_done;
    logic [FIELD_W-1:0]   o_chosen_action;
    logic                 o_explored;
    logic signed [DATA_W-1:0] o_new_value;
    logic [DATA_W-1:0]    o_epsilon_now;

    tabular_q_learning_agent #(
        .STATE_COUNT (STATES),
        .ACTION_COUNT(ACTIONS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_cur_state      (i_cur_state),
        .i_taken_action   (i_taken_action),
        .i_following_state(i_following_state),
        .i_reward_value   (i_reward_value),
        .i_random_draw    (i_random_draw),
        .i_random_action  (i_random_action),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_chosen_action  (o_chosen_action),
        .o_explored       (o_explored),
        .o_new_value      (o_new_value),
        .o_epsilon_now    (o_epsilon_now)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the agent: Q table, epsilon and the register file
    t_q88              q_table [STATES*ACTIONS];
    logic [DATA_W-1:0] alpha, gamma, eps_decay, eps_floor, eps_start, eps;
    logic              learning;

    t_agent_cmd   words_todo [$];
    t_agent_reply replies_due [$];
    bit           failed = 1'b0;
    int unsigned  cycles = 0;

    function automatic int fit_state(logic [FIELD_W-1:0] s);
        return (s >= STATES) ? STATES - 1 : int'(s);
    endfunction

    function automatic int fit_action(logic [FIELD_W-1:0] a);
        return (a >= ACTIONS) ? ACTIONS - 1 : int'(a);
    endfunction

    // First action holding the row maximum
    function automatic int greedy_action(int s);
        int best;
        best = 0;
        for (int a = 1; a < ACTIONS; a++)
            if (q_table[s*ACTIONS+a] > q_table[s*ACTIONS+best])
                best = a;
        return best;
    endfunction

    function automatic void clear_agent();
        for (int i = 0; i < STATES*ACTIONS; i++)
            q_table[i] = '0;
        eps = eps_start;
    endfunction

    function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        case (idx)
            REG_LEARN_RATE:    alpha = val;
            REG_DISCOUNT:      gamma = val;
            REG_EXPLORE_DECAY: eps_decay = val;
            REG_EXPLORE_FLOOR: eps_floor = val;
            REG_EXPLORE_START: eps_start = val;
            REG_TRAINING_ON: begin
                learning = val[0];
                if (!val[0])
                    eps = '0;
            end
            default: ;
        endcase
    endfunction

    // Advance the shadow by one command word and return the reply it yields
    function automatic t_agent_reply agent_step(t_agent_cmd c);
        t_agent_reply r;
        int cs, ta, fs;
        longint entry, row_max, target, prod, nv;
        r  = '0;
        cs = fit_state(c.cur_state);
        ta = fit_action(c.taken_action);
        fs = fit_state(c.following_state);
        case (c.opcode)
            OP_SELECT: begin
                if (learning && c.draw < eps) begin
                    r.chosen_action = FIELD_W'(fit_action(c.rand_action));
                    r.explored      = 1'b1;
                end else begin
                    r.chosen_action = FIELD_W'(greedy_action(cs));
                end
            end
            OP_UPDATE: begin
                if (learning) begin
                    entry   = q_table[cs*ACTIONS+ta];
                    row_max = q_table[fs*ACTIONS+greedy_action(fs)];
                    target  = longint'($signed(c.reward)) * 65536
                            + longint'(gamma) * row_max - entry * 65536;
                    prod    = longint'(alpha) * target + (longint'(1) << 31);
                    nv      = entry + (prod >>> 32);
                    if (nv > 32767)
                        nv = 32767;
                    if (nv < -32768)
                        nv = -32768;
                    q_table[cs*ACTIONS+ta] = t_q88'(nv);
                    r.new_value = DATA_W'(nv);
                    if (eps > eps_floor)
                        eps = DATA_W'((32'(eps) * 32'(eps_decay)) >> 16);
                end
            end
            OP_CLEAR: begin
                clear_agent();
                learning = 1'b1;
            end
            default: ;
        endcase
        r.epsilon_now = eps;
        return r;
    endfunction

    // Driver: bursts of words with random gaps counted from each acceptance
    t_agent_cmd cur_word;
    int         burst_left = 0;
    int         gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                replies_due.push_back(agent_step(cur_word));
            if (start && busy) begin
                // hold the word until taken
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (words_todo.size() > 0) begin
                cur_word          = words_todo.pop_front();
                i_opcode          <= cur_word.opcode;
                i_cur_state       <= cur_word.cur_state;
                i_taken_action    <= cur_word.taken_action;
                i_following_state <= cur_word.following_state;
                i_reward_value    <= cur_word.reward;
                i_random_draw     <= cur_word.draw;
                i_random_action   <= cur_word.rand_action;
                start             <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result word retires the oldest expectation
    always @(posedge i_clk) begin
        t_agent_reply want;
        if (i_rst_n && o_done) begin
            if (replies_due.size() == 0) begin
                $error("result word with nothing pending");
                failed = 1'b1;
            end else begin
                want = replies_due.pop_front();
                if (o_chosen_action !== want.chosen_action) begin
                    $error("chosen_action: expected %0d, got %0d",
                           want.chosen_action, o_chosen_action);
                    failed = 1'b1;
                end
                if (o_explored !== want.explored) begin
                    $error("explored: expected %0d, got %0d", want.explored, o_explored);
                    failed = 1'b1;
                end
                if (o_new_value !== want.new_value) begin
                    $error("new_value: expected %0d, got %0d",
                           $signed(want.new_value), o_new_value);
                    failed = 1'b1;
                end
                if (o_epsilon_now !== want.epsilon_now) begin
                    $error("epsilon_now: expected %0d, got %0d",
                           want.epsilon_now, o_epsilon_now);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** tabular_q_learning_agent: FAILED **");
            $finish;
        end
    end

    function automatic void queue_word(logic [FIELD_W-1:0] op, logic [FIELD_W-1:0] cs,
                                       logic [FIELD_W-1:0] ta, logic [FIELD_W-1:0] fs,
                                       logic [DATA_W-1:0] rw, logic [DATA_W-1:0] draw,
                                       logic [FIELD_W-1:0] ra);
        t_agent_cmd c;
        c.opcode          = op;
        c.cur_state       = cs;
        c.taken_action    = ta;
        c.following_state = fs;
        c.reward          = rw;
        c.draw            = draw;
        c.rand_action     = ra;
        words_todo.push_back(c);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_index();
        return ($urandom_range(0, 9) == 0) ? FIELD_W'(3) : FIELD_W'($urandom_range(0, 2));
    endfunction

    // Mostly select/update traffic so the table fills; rare clears and junk opcodes
    function automatic void queue_random_word();
        logic [FIELD_W-1:0] op;
        logic [DATA_W-1:0]  rw;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_SELECT;
        else if (pick < 92)
            op = OP_UPDATE;
        else if (pick < 95)
            op = OP_CLEAR;
        else if (pick < 97)
            op = OP_NOP;
        else
            op = FIELD_W'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0)
            rw = DATA_W'(int'($urandom_range(0, 2047)) - 1024);
        else
            rw = DATA_W'($urandom);
        queue_word(op, rand_index(), rand_index(), rand_index(), rw,
                   DATA_W'($urandom), FIELD_W'($urandom_range(0, 3)));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return DATA_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        set_reg(idx, val);
        i_cfg_we <= 1'b0;
    endtask

    // Pause the sender until every pending word has been answered
    task automatic drain();
        while (words_todo.size() != 0 || start || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        alpha     = LEARN_RATE_RST;
        gamma     = DISCOUNT_RST;
        eps_decay = EXPLORE_DECAY_RST;
        eps_floor = EXPLORE_FLOOR_RST;
        eps_start = EXPLORE_START_RST;
        learning  = 1'b1;
        clear_agent();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default settings: explore boundary, clamped indexes, extreme rewards
        queue_word(OP_SELECT, 2'd0, 2'd0, 2'd0, 16'h0000, 16'd0, 2'd1);
        queue_word(OP_SELECT, 2'd1, 2'd0, 2'd0, 16'h0000, 16'hFFFF, 2'd2);
        queue_word(OP_SELECT, 2'd3, 2'd0, 2'd0, 16'h0000, EXPLORE_START_RST, 2'd1);
        queue_word(OP_SELECT, 2'd0, 2'd0, 2'd0, 16'h0000, EXPLORE_START_RST - 16'd1, 2'd3);
        queue_word(OP_UPDATE, 2'd0, 2'd1, 2'd0, 16'h7FFF, 16'h0000, 2'd0);
        queue_word(OP_UPDATE, 2'd0, 2'd2, 2'd0, 16'h8000, 16'hFFFF, 2'd3);
        queue_word(OP_SELECT, 2'd0, 2'd0, 2'd0, 16'h0000, 16'hFFFF, 2'd0);
        queue_word(OP_UPDATE, 2'd3, 2'd3, 2'd3, 16'h0100, 16'h5555, 2'd2);
        queue_word(OP_UPDATE, 2'd1, 2'd0, 2'd0, 16'hFF00, 16'hAAAA, 2'd1);
        queue_word(OP_NOP,    2'd3, 2'd3, 2'd3, 16'hFFFF, 16'hFFFF, 2'd3);
        queue_word(OP_CLEAR,  2'd1, 2'd2, 2'd1, 16'h1234, 16'h0000, 2'd0);
        queue_word(OP_SELECT, 2'd0, 2'd0, 2'd0, 16'h0000, 16'hFFFF, 2'd0);
        drain();

        // full step and discount: drive entries into both saturation limits
        write_reg(REG_LEARN_RATE, 16'hFFFF);
        write_reg(REG_DISCOUNT, 16'hFFFF);
        write_reg(REG_EXPLORE_DECAY, 16'h0000);
        repeat (3) queue_word(OP_UPDATE, 2'd1, 2'd1, 2'd1, 16'h7FFF, 16'h0000, 2'd0);
        repeat (3) queue_word(OP_UPDATE, 2'd2, 2'd0, 2'd2, 16'h8000, 16'h0000, 2'd0);
        queue_word(OP_SELECT, 2'd2, 2'd0, 2'd0, 16'h0000, 16'h0000, 2'd2);
        drain();

        // training off: greedy only, updates ignored, epsilon held at zero after re-enable
        write_reg(REG_TRAINING_ON, 16'hFFFE);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0001);
        queue_word(OP_SELECT, 2'd1, 2'd0, 2'd0, 16'h0000, 16'h0000, 2'd2);
        queue_word(OP_UPDATE, 2'd1, 2'd1, 2'd0, 16'h7FFF, 16'h0000, 2'd0);
        drain();
        write_reg(REG_TRAINING_ON, 16'h0001);
        write_reg(REG_EXPLORE_START, 16'hFFFF);
        write_reg(REG_EXPLORE_FLOOR, 16'hFFFF);
        queue_word(OP_SELECT, 2'd1, 2'd0, 2'd0, 16'h0000, 16'h0000, 2'd2);
        queue_word(OP_CLEAR,  2'd0, 2'd0, 2'd0, 16'h0000, 16'h0000, 2'd0);
        queue_word(OP_SELECT, 2'd0, 2'd0, 2'd0, 16'h0000, 16'hFFFE, 2'd2);
        queue_word(OP_UPDATE, 2'd0, 2'd0, 2'd1, 16'h0200, 16'h0000, 2'd0);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            write_reg(REG_LEARN_RATE, pick_value());
            write_reg(REG_DISCOUNT, pick_value());
            write_reg(REG_EXPLORE_DECAY,
                      ($urandom_range(0, 1) == 0) ? pick_value()
                                                  : DATA_W'($urandom_range(60000, 65535)));
            write_reg(REG_EXPLORE_FLOOR,
                      ($urandom_range(0, 1) == 0) ? pick_value()
                                                  : DATA_W'($urandom_range(0, 4000)));
            write_reg(REG_EXPLORE_START, pick_value());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, DATA_W'($urandom));
            write_reg(REG_TRAINING_ON,
                      {(DATA_W-1)'($urandom), ($urandom_range(0, 4) != 0)});
            for (int n = 0; n < PHASE_WORDS; n++)
                queue_random_word();
            drain();
        end

        if (!failed)
            $display("** tabular_q_learning_agent: PASSED **");
        else
            $display("** tabular_q_learning_agent: FAILED **");
        $finish;
    end

endmodule
